[hdl/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tpf_pkg.sv]
package tpf_pkg;

   localparam int IFRAC   = 30;
   localparam int DW      = 30;
   localparam int LEN_W   = 31;
   localparam int SUM_W   = 62;
   localparam int NUM_W   = 61;
   localparam int R_W     = 62;
   localparam int HALF_W  = 31;
   localparam int AREA_RW = 126;
   localparam int AREA_QW = 63;
   localparam int UNIT_W  = 16;
   localparam int AREA_W  = 51;
   localparam int VAL_W   = 32;
   localparam int PROD_W  = 64;

   localparam logic [AREA_W-1:0] AREA_MAX = '1;
   localparam logic [UNIT_W-1:0] SAT_POS  = 16'h7fff;
   localparam logic [UNIT_W-1:0] SAT_NEG  = 16'h8000;

   typedef struct packed {
      logic                valid;
      logic [2:0][DW-1:0]  dn;
      logic [1:0][DW-1:0]  ds;
      logic [2:0]          neg;
      logic                degen;
      logic                horiz;
      logic                p1pos;
   } side_type;

endpackage

[hdl/triangle_patch_frame.sv]
// fully pipelined, one item accepted per clock, busy is never raised
// each item passes the front stages, then its lengths pass two 31-stage units in turn
// (square root, then divide) before the rounding stage puts the result on the rsp ports
// reset is synchronous and clears every valid bit; items in flight are dropped
// the receiver cannot stall, every strobe delivers one item
`include "assert_macros.svh"

module triangle_patch_frame #(
   parameter int COORD_BITS     = 24,
   parameter int UNIT_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_BITS-1:0]        req_p1_east,
   input  logic signed [COORD_BITS-1:0]        req_p1_north,
   input  logic signed [COORD_BITS-1:0]        req_p1_up,
   input  logic signed [COORD_BITS-1:0]        req_p2_east,
   input  logic signed [COORD_BITS-1:0]        req_p2_north,
   input  logic signed [COORD_BITS-1:0]        req_p2_up,
   input  logic signed [COORD_BITS-1:0]        req_p3_east,
   input  logic signed [COORD_BITS-1:0]        req_p3_north,
   input  logic signed [COORD_BITS-1:0]        req_p3_up,
   output logic                                strobe,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_normal_east,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_normal_north,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_normal_up,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_strike_east,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_strike_north,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_strike_up,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_dip_east,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_dip_north,
   output logic signed [tpf_pkg::UNIT_W-1:0]   rsp_dip_up,
   output logic        [tpf_pkg::AREA_W-1:0]   rsp_patch_area,
   output logic                                rsp_degenerate
);

   localparam int DIF_W     = COORD_BITS + 1;
   localparam int PRD_W     = 2 * DIF_W;
   localparam int CRS_W     = PRD_W + 1;
   localparam int MAG_W     = PRD_W;
   localparam int BL_W      = $clog2(MAG_W + 1);
   localparam int EXT_W     = (MAG_W > tpf_pkg::R_W) ? MAG_W : tpf_pkg::R_W;
   localparam int AW        = 64 + MAG_W;
   localparam int RND_N     = tpf_pkg::IFRAC - UNIT_FRAC_BITS;
   localparam int RND_D     = 2 * tpf_pkg::IFRAC - UNIT_FRAC_BITS;
   localparam int SIDE_W    = $bits(tpf_pkg::side_type);
   localparam int A_PAD     = 2 * tpf_pkg::LEN_W + 3 - (tpf_pkg::AREA_QW + 1);
   localparam int TOTAL_LAT = 8 + 2 * tpf_pkg::LEN_W + 4;

   localparam int DW     = tpf_pkg::DW;
   localparam int R_W    = tpf_pkg::R_W;
   localparam int HALF_W = tpf_pkg::HALF_W;
   localparam int VAL_W  = tpf_pkg::VAL_W;
   localparam int PROD_W = tpf_pkg::PROD_W;
   localparam int UNIT_W = tpf_pkg::UNIT_W;

   function automatic logic [UNIT_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                 input int sh);
      logic [63:0] mag;
      logic        neg;
      neg = v[63];
      mag = neg ? 64'(-v) : 64'(v);
      if (sh > 0) begin
         mag = (mag + (64'd1 << (sh - 1))) >> sh;
      end
      if (neg) begin
         rnd_sat = (mag > 64'd32768) ? tpf_pkg::SAT_NEG : UNIT_W'(-mag);
      end else begin
         rnd_sat = (mag > 64'd32767) ? tpf_pkg::SAT_POS : UNIT_W'(mag);
      end
   endfunction

   function automatic logic [BL_W-1:0] bitlen(input logic [MAG_W-1:0] v);
      logic [BL_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            n = BL_W'(i + 1);
         end
      end
      return n;
   endfunction

   assign busy = 1'b0;

   // stage 1: edge vectors
   logic signed [COORD_BITS-1:0] pt [9];
   logic signed [DIF_W-1:0]      a_in [3];
   logic signed [DIF_W-1:0]      b_in [3];
   logic signed [DIF_W-1:0]      a_ff [3];
   logic signed [DIF_W-1:0]      b_ff [3];
   logic                         v1_in, v1_ff, p1pos1_in, p1pos1_ff;

   assign pt[0] = req_p1_east;
   assign pt[1] = req_p1_north;
   assign pt[2] = req_p1_up;
   assign pt[3] = req_p2_east;
   assign pt[4] = req_p2_north;
   assign pt[5] = req_p2_up;
   assign pt[6] = req_p3_east;
   assign pt[7] = req_p3_north;
   assign pt[8] = req_p3_up;

   always_comb begin
      v1_in     = start & ~busy;
      p1pos1_in = (req_p1_up > 0);
      for (int i = 0; i < 3; i++) begin
         a_in[i] = DIF_W'(pt[3+i]) - DIF_W'(pt[i]);
         b_in[i] = DIF_W'(pt[6+i]) - DIF_W'(pt[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      p1pos1_ff <= p1pos1_in;
   end

   // stage 2: cross product terms
   logic signed [PRD_W-1:0] prd_in [6];
   logic signed [PRD_W-1:0] prd_ff [6];
   logic                    v2_ff, p1pos2_ff;

   always_comb begin
      prd_in[0] = PRD_W'(a_ff[1]) * PRD_W'(b_ff[2]);
      prd_in[1] = PRD_W'(a_ff[2]) * PRD_W'(b_ff[1]);
      prd_in[2] = PRD_W'(a_ff[2]) * PRD_W'(b_ff[0]);
      prd_in[3] = PRD_W'(a_ff[0]) * PRD_W'(b_ff[2]);
      prd_in[4] = PRD_W'(a_ff[0]) * PRD_W'(b_ff[1]);
      prd_in[5] = PRD_W'(a_ff[1]) * PRD_W'(b_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      prd_ff    <= prd_in;
      p1pos2_ff <= p1pos1_ff;
   end

   // stage 3: cross product, magnitudes, upward flip
   logic signed [CRS_W-1:0] crs [3];
   logic [2:0]              sgn;
   logic [MAG_W-1:0]        mag_in [3];
   logic [MAG_W-1:0]        mag_ff [3];
   logic [2:0]              neg3_in, neg3_ff;
   logic                    v3_ff, p1pos3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crs[i]    = CRS_W'(prd_ff[2*i]) - CRS_W'(prd_ff[2*i+1]);
         sgn[i]    = crs[i][CRS_W-1];
         mag_in[i] = sgn[i] ? MAG_W'(-crs[i]) : MAG_W'(crs[i]);
      end
      neg3_in = sgn ^ {3{sgn[2]}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      mag_ff    <= mag_in;
      neg3_ff   <= neg3_in;
      p1pos3_ff <= p1pos2_ff;
   end

   // stage 4: leading one search
   logic [BL_W-1:0]  bl_all_in, bl_all_ff, bl_h_in, bl_h_ff;
   logic [MAG_W-1:0] mag4_ff [3];
   logic [2:0]       neg4_ff;
   logic             v4_ff, p1pos4_ff;

   assign bl_all_in = bitlen(mag_ff[0] | mag_ff[1] | mag_ff[2]);
   assign bl_h_in   = bitlen(mag_ff[0] | mag_ff[1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      bl_all_ff <= bl_all_in;
      bl_h_ff   <= bl_h_in;
      mag4_ff   <= mag_ff;
      neg4_ff   <= neg3_ff;
      p1pos4_ff <= p1pos3_ff;
   end

   // stage 5: normalizing shifts
   tpf_pkg::side_type side5_in, side5_ff;
   logic [BL_W-1:0]   k5_in, k5_ff;
   logic [R_W-1:0]    r5_in [3];
   logic [R_W-1:0]    r5_ff [3];

   always_comb begin
      side5_in       = '0;
      side5_in.valid = v4_ff;
      side5_in.neg   = neg4_ff;
      side5_in.degen = (bl_all_ff == '0);
      side5_in.horiz = (bl_h_ff == '0);
      side5_in.p1pos = p1pos4_ff;
      k5_in = (bl_all_ff > BL_W'(R_W)) ? bl_all_ff - BL_W'(R_W) : '0;
      for (int i = 0; i < 3; i++) begin
         side5_in.dn[i] = DW'({mag4_ff[i], DW'(0)} >> bl_all_ff);
         r5_in[i]       = R_W'(EXT_W'(mag4_ff[i]) >> k5_in);
      end
      for (int i = 0; i < 2; i++) begin
         side5_in.ds[i] = DW'({mag4_ff[i], DW'(0)} >> bl_h_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side5_ff <= '0;
      end else begin
         side5_ff <= side5_in;
      end
      k5_ff <= k5_in;
      r5_ff <= r5_in;
   end

   // stage 6: squares and partial products
   logic [2*DW-1:0]     sqn6_ff [3];
   logic [2*DW-1:0]     sqs6_ff [2];
   logic [2*HALF_W-1:0] hh_ff [3];
   logic [2*HALF_W-1:0] hl_ff [3];
   logic [2*HALF_W-1:0] ll_ff [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sqn6_ff[i] <= (2*DW)'(side5_ff.dn[i]) * (2*DW)'(side5_ff.dn[i]);
         hh_ff[i]   <= (2*HALF_W)'(r5_ff[i][R_W-1:HALF_W])
                     * (2*HALF_W)'(r5_ff[i][R_W-1:HALF_W]);
         hl_ff[i]   <= (2*HALF_W)'(r5_ff[i][R_W-1:HALF_W])
                     * (2*HALF_W)'(r5_ff[i][HALF_W-1:0]);
         ll_ff[i]   <= (2*HALF_W)'(r5_ff[i][HALF_W-1:0])
                     * (2*HALF_W)'(r5_ff[i][HALF_W-1:0]);
      end
      for (int i = 0; i < 2; i++) begin
         sqs6_ff[i] <= (2*DW)'(side5_ff.ds[i]) * (2*DW)'(side5_ff.ds[i]);
      end
   end

   // stage 7: per-component area squares
   logic [tpf_pkg::AREA_RW-1:0] asq7_ff [3];
   logic [2*DW-1:0]             sqn7_ff [3];
   logic [2*DW-1:0]             sqs7_ff [2];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         asq7_ff[i] <= (tpf_pkg::AREA_RW'(hh_ff[i]) << (2 * HALF_W))
                     + (tpf_pkg::AREA_RW'(hl_ff[i]) << (HALF_W + 1))
                     + tpf_pkg::AREA_RW'(ll_ff[i]);
      end
      sqn7_ff <= sqn6_ff;
      sqs7_ff <= sqs6_ff;
   end

   // stage 8: sums of squares
   logic [tpf_pkg::AREA_RW-1:0] suma8_ff;
   logic [tpf_pkg::SUM_W-1:0]   sumn8_ff, sums8_ff;
   logic [SIDE_W-1:0]           side8_vec;
   logic [BL_W-1:0]             k8;

   always_ff @(posedge clock) begin
      suma8_ff <= asq7_ff[0] + asq7_ff[1] + asq7_ff[2];
      sumn8_ff <= tpf_pkg::SUM_W'(sqn7_ff[0]) + tpf_pkg::SUM_W'(sqn7_ff[1])
                + tpf_pkg::SUM_W'(sqn7_ff[2]);
      sums8_ff <= tpf_pkg::SUM_W'(sqs7_ff[0]) + tpf_pkg::SUM_W'(sqs7_ff[1]);
   end

   tpf_delay #(.WIDTH(SIDE_W), .DEPTH(3)) u_side8 (
      .clock (clock), .reset (reset), .din (side5_ff), .dout (side8_vec)
   );

   tpf_delay #(.WIDTH(BL_W), .DEPTH(3)) u_k8 (
      .clock (clock), .reset (reset), .din (k5_ff), .dout (k8)
   );

   // lengths
   logic [tpf_pkg::LEN_W-1:0] len_n, len_s;
   logic [SIDE_W-1:0]         side_b1_vec, side_b2_vec;
   tpf_pkg::side_type         side_b1, side_b2;

   tpf_sqrt #(.RAD_W(tpf_pkg::SUM_W), .ROOT_W(tpf_pkg::LEN_W)) u_sqrt_n (
      .clock (clock), .radicand (sumn8_ff), .root (len_n)
   );
   tpf_sqrt #(.RAD_W(tpf_pkg::SUM_W), .ROOT_W(tpf_pkg::LEN_W)) u_sqrt_s (
      .clock (clock), .radicand (sums8_ff), .root (len_s)
   );
   tpf_delay #(.WIDTH(SIDE_W), .DEPTH(tpf_pkg::LEN_W)) u_side_b1 (
      .clock (clock), .reset (reset), .din (side8_vec), .dout (side_b1_vec)
   );
   assign side_b1 = side_b1_vec;

   // unit components
   logic [tpf_pkg::NUM_W-1:0] num_n [3];
   logic [tpf_pkg::NUM_W-1:0] num_s [2];
   logic [tpf_pkg::LEN_W-1:0] quo_n [3];
   logic [tpf_pkg::LEN_W-1:0] quo_s [2];

   for (genvar i = 0; i < 3; i++) begin : g_div_n
      assign num_n[i] = (tpf_pkg::NUM_W'(side_b1.dn[i]) << tpf_pkg::IFRAC)
                      + tpf_pkg::NUM_W'(len_n >> 1);
      tpf_div #(.NUM_W(tpf_pkg::NUM_W), .DEN_W(tpf_pkg::LEN_W),
                .QUO_W(tpf_pkg::LEN_W)) u_div (
         .clock (clock), .num (num_n[i]), .den (len_n), .quo (quo_n[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_div_s
      assign num_s[i] = (tpf_pkg::NUM_W'(side_b1.ds[i]) << tpf_pkg::IFRAC)
                      + tpf_pkg::NUM_W'(len_s >> 1);
      tpf_div #(.NUM_W(tpf_pkg::NUM_W), .DEN_W(tpf_pkg::LEN_W),
                .QUO_W(tpf_pkg::LEN_W)) u_div (
         .clock (clock), .num (num_s[i]), .den (len_s), .quo (quo_s[i])
      );
   end

   tpf_delay #(.WIDTH(SIDE_W), .DEPTH(tpf_pkg::LEN_W)) u_side_b2 (
      .clock (clock), .reset (reset), .din (side_b1_vec), .dout (side_b2_vec)
   );
   assign side_b2 = side_b2_vec;

   // stage a: signed q30 components
   logic signed [VAL_W-1:0] n30_in [3];
   logic signed [VAL_W-1:0] s30_in [2];
   logic signed [VAL_W-1:0] n30a_ff [3];
   logic signed [VAL_W-1:0] s30a_ff [2];
   logic                    va_ff, dga_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n30_in[i] = side_b2.neg[i] ? -$signed({1'b0, quo_n[i]})
                                    : $signed({1'b0, quo_n[i]});
      end
      if (side_b2.horiz) begin
         s30_in[0] = '0;
         s30_in[1] = side_b2.p1pos ? -(VAL_W'(1) <<< tpf_pkg::IFRAC)
                                   : (VAL_W'(1) <<< tpf_pkg::IFRAC);
      end else begin
         s30_in[0] = side_b2.neg[1] ? $signed({1'b0, quo_s[1]}) : -$signed({1'b0, quo_s[1]});
         s30_in[1] = side_b2.neg[0] ? -$signed({1'b0, quo_s[0]}) : $signed({1'b0, quo_s[0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= side_b2.valid;
      end
      n30a_ff <= n30_in;
      s30a_ff <= s30_in;
      dga_ff  <= side_b2.degen;
   end

   // stage b: dip products
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [VAL_W-1:0]  n30b_ff [3];
   logic signed [VAL_W-1:0]  s30b_ff [2];
   logic                     vb_ff, dgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      pa_ff   <= PROD_W'(n30a_ff[2]) * PROD_W'(s30a_ff[1]);
      pb_ff   <= PROD_W'(n30a_ff[2]) * PROD_W'(s30a_ff[0]);
      pc_ff   <= PROD_W'(n30a_ff[0]) * PROD_W'(s30a_ff[1]);
      pd_ff   <= PROD_W'(n30a_ff[1]) * PROD_W'(s30a_ff[0]);
      n30b_ff <= n30a_ff;
      s30b_ff <= s30a_ff;
      dgb_ff  <= dga_ff;
   end

   // stage c: dip vector
   logic signed [PROD_W-1:0] dip_ff [3];
   logic signed [VAL_W-1:0]  n30c_ff [3];
   logic signed [VAL_W-1:0]  s30c_ff [2];
   logic                     vc_ff, dgc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      dip_ff[0] <= -pa_ff;
      dip_ff[1] <= pb_ff;
      dip_ff[2] <= pc_ff - pd_ff;
      n30c_ff   <= n30b_ff;
      s30c_ff   <= s30b_ff;
      dgc_ff    <= dgb_ff;
   end

   // area path
   logic [tpf_pkg::AREA_QW-1:0] q_a;
   logic [BL_W-1:0]             k_a;
   logic [AW-1:0]               area_wide;
   logic [tpf_pkg::AREA_W-1:0]  area_in, area_ff, area_pad;

   tpf_sqrt #(.RAD_W(tpf_pkg::AREA_RW), .ROOT_W(tpf_pkg::AREA_QW)) u_sqrt_a (
      .clock (clock), .radicand (suma8_ff), .root (q_a)
   );
   tpf_delay #(.WIDTH(BL_W), .DEPTH(tpf_pkg::AREA_QW)) u_k_a (
      .clock (clock), .reset (reset), .din (k8), .dout (k_a)
   );

   always_comb begin
      if (k_a == '0) begin
         area_wide = (AW'(q_a) + AW'(1)) >> 1;
      end else begin
         area_wide = AW'(q_a) << (k_a - BL_W'(1));
      end
      area_in = (area_wide > AW'(tpf_pkg::AREA_MAX)) ? tpf_pkg::AREA_MAX
                                                     : tpf_pkg::AREA_W'(area_wide);
   end

   always_ff @(posedge clock) begin
      area_ff <= area_in;
   end

   tpf_delay #(.WIDTH(tpf_pkg::AREA_W), .DEPTH(A_PAD)) u_area_pad (
      .clock (clock), .reset (reset), .din (area_ff), .dout (area_pad)
   );

   // stage d: rounding, saturation, result registers
   logic [UNIT_W-1:0]          out_in [9];
   logic [UNIT_W-1:0]          out_ff [9];
   logic [tpf_pkg::AREA_W-1:0] area_out_ff;
   logic                       strobe_ff, degen_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_in[i]     = rnd_sat(64'(n30c_ff[i]), RND_N);
         out_in[6 + i] = rnd_sat(dip_ff[i], RND_D);
      end
      out_in[3] = rnd_sat(64'(s30c_ff[0]), RND_N);
      out_in[4] = rnd_sat(64'(s30c_ff[1]), RND_N);
      out_in[5] = '0;
      if (dgc_ff) begin
         for (int i = 0; i < 9; i++) begin
            out_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vc_ff;
      end
      out_ff      <= out_in;
      area_out_ff <= area_pad;
      degen_ff    <= dgc_ff;
   end

   assign strobe           = strobe_ff;
   assign rsp_normal_east  = out_ff[0];
   assign rsp_normal_north = out_ff[1];
   assign rsp_normal_up    = out_ff[2];
   assign rsp_strike_east  = out_ff[3];
   assign rsp_strike_north = out_ff[4];
   assign rsp_strike_up    = out_ff[5];
   assign rsp_dip_east     = out_ff[6];
   assign rsp_dip_north    = out_ff[7];
   assign rsp_dip_up       = out_ff[8];
   assign rsp_patch_area   = area_out_ff;
   assign rsp_degenerate   = degen_ff;

   `TPF_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, v1_ff,
                    "accepted item not in pipe")
   `TPF_ASSERT_NOW(a_result_latency, clock, reset, strobe, $past(start, TOTAL_LAT),
                   "result without item")
   `TPF_ASSERT_NOW(a_degen_zero, clock, reset, strobe && rsp_degenerate,
                   rsp_patch_area == '0 && rsp_normal_up == '0, "degenerate item not zero")
   `TPF_ASSERT_NOW(a_normal_up, clock, reset, strobe,
                   !rsp_normal_up[UNIT_W-1] && rsp_strike_up == '0, "frame sign wrong")

endmodule

[hdl/tpf_delay.sv]
module tpf_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];
   logic [WIDTH-1:0] line_in [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         line_in[i] = (i == 0) ? din : line_ff[(i == 0) ? 0 : i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         line_ff <= line_in;
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

[hdl/tpf_sqrt.sv]
module tpf_sqrt #(
   parameter int RAD_W  = 62,
   parameter int ROOT_W = 31
) (
   input  logic              clock,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int B = ROOT_W - 1 - j;
      logic [RAD_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  trial;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // (r + 2^b)^2 - r^2
      assign trial = (RAD_W'(root_prev) << (B + 1)) | (RAD_W'(1) << (2 * B));

      always_comb begin
         if (trial <= rem_prev) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

[hdl/tpf_div.sv]
module tpf_div #(
   parameter int NUM_W = 61,
   parameter int DEN_W = 31,
   parameter int QUO_W = 31
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int B = QUO_W - 1 - j;
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [NUM_W-1:0] sub;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign sub = NUM_W'(den_prev) << B;

      always_comb begin
         if (rem_prev >= sub) begin
            rem_in = rem_prev - sub;
            quo_in = quo_prev | (QUO_W'(1) << B);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_prev;
         quo_ff[j] <= quo_in;
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

[verif/triangle_patch_frame_checker.sv]
`timescale 1ns / 100ps

module triangle_patch_frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [23:0]                       req_p1_east,
   input  logic [23:0]                       req_p1_north,
   input  logic [23:0]                       req_p1_up,
   input  logic [23:0]                       req_p2_east,
   input  logic [23:0]                       req_p2_north,
   input  logic [23:0]                       req_p2_up,
   input  logic [23:0]                       req_p3_east,
   input  logic [23:0]                       req_p3_north,
   input  logic [23:0]                       req_p3_up,
   input  logic                              strobe,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_normal_east,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_normal_north,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_normal_up,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_strike_east,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_strike_north,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_strike_up,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_dip_east,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_dip_north,
   input  logic [tpf_pkg::UNIT_W-1:0]        rsp_dip_up,
   input  logic [tpf_pkg::AREA_W-1:0]        rsp_patch_area,
   input  logic                              rsp_degenerate,
   output int                                errors,
   output int                                pending,
   output int                                flat_count
);

   typedef struct packed {
      logic [15:0] ne, nn, nu, se, sn, su, de, dn, du;
      logic [50:0] area;
      logic        degen;
   } frame_t;

   frame_t frame_q[$];

   function automatic logic [63:0] isqrt128(input logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         t  = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= s) r = t;
      end
      return r;
   endfunction

   function automatic int bitlen128(input logic [127:0] x);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (x[i]) n = i + 1;
      return n;
   endfunction

   // largest magnitude lands in [2^29, 2^30)
   function automatic logic [2:0][63:0] scale_q30(input logic [2:0][127:0] m, input int cnt);
      int bmax;
      int x;
      logic [2:0][63:0] d;
      logic [127:0] w;
      bmax = 0;
      d    = '0;
      for (int i = 0; i < cnt; i++) begin
         x = bitlen128(m[i]);
         if (x > bmax) bmax = x;
      end
      for (int i = 0; i < cnt; i++) begin
         if (bmax > 30) w = m[i] >> (bmax - 30);
         else w = m[i] << (30 - bmax);
         d[i] = w[63:0];
      end
      return d;
   endfunction

   function automatic longint signed unit_q30(input logic [63:0] d, input logic [63:0] len,
                                              input bit ng);
      logic [63:0] u;
      u = ((d << 30) + (len >> 1)) / len;
      return ng ? -longint'(u) : longint'(u);
   endfunction

   function automatic logic [15:0] to_unit(input longint signed v, input int sh);
      logic [63:0]    u;
      longint signed  w;
      u = (v < 0) ? 64'(-v) : 64'(v);
      u = (u + (64'd1 << (sh - 1))) >> sh;
      w = (v < 0) ? -longint'(u) : longint'(u);
      if (w > 32767) w = 32767;
      if (w < -32768) w = -32768;
      return w[15:0];
   endfunction

   function automatic frame_t predict_frame(input logic [8:0][23:0] v);
      longint signed    p[9];
      longint signed    a[3];
      longint signed    bv[3];
      longint signed    cx;
      logic [2:0][127:0] m;
      logic [2:0][127:0] r;
      logic [127:0]     s;
      logic [127:0]     areaw;
      logic [127:0]     cap;
      bit               ng[3];
      bit               flip;
      logic [63:0]      q;
      logic [63:0]      len;
      logic [2:0][63:0] d;
      longint signed    n30[3];
      longint signed    s30[3];
      longint signed    dip[3];
      int               k;
      frame_t           f;
      for (int i = 0; i < 9; i++) p[i] = {{40{v[i][23]}}, v[i]};
      for (int i = 0; i < 3; i++) begin
         a[i]  = p[3 + i] - p[i];
         bv[i] = p[6 + i] - p[i];
      end
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: cx = a[1] * bv[2] - a[2] * bv[1];
            1: cx = a[2] * bv[0] - a[0] * bv[2];
            default: cx = a[0] * bv[1] - a[1] * bv[0];
         endcase
         ng[i] = cx < 0;
         m[i]  = {64'd0, (cx < 0) ? 64'(-cx) : 64'(cx)};
      end
      flip = ng[2];
      for (int i = 0; i < 3; i++) ng[i] = ng[i] ^ flip;

      r = m;
      k = 0;
      while ((r[0] >> 62) != 0 || (r[1] >> 62) != 0 || (r[2] >> 62) != 0) begin
         for (int i = 0; i < 3; i++) r[i] = r[i] >> 1;
         k++;
      end
      s = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
      q = isqrt128(s);
      cap = {77'd0, tpf_pkg::AREA_MAX};
      if (k == 0) areaw = ({64'd0, q} + 1) >> 1;
      else if ({64'd0, q} > (cap >> (k - 1))) areaw = cap;
      else areaw = {64'd0, q} << (k - 1);
      if (areaw > cap) areaw = cap;

      f      = '0;
      f.area = areaw[50:0];
      if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
         f.degen = 1'b1;
         return f;
      end

      d   = scale_q30(m, 3);
      len = isqrt128({64'd0, d[0]} * d[0] + {64'd0, d[1]} * d[1] + {64'd0, d[2]} * d[2]);
      for (int i = 0; i < 3; i++) n30[i] = unit_q30(d[i], len, ng[i]);

      if (m[0] == 0 && m[1] == 0) begin
         s30[0] = 0;
         s30[1] = (p[2] > 0) ? -(longint'(1) << 30) : (longint'(1) << 30);
      end else begin
         d      = scale_q30(m, 2);
         len    = isqrt128({64'd0, d[0]} * d[0] + {64'd0, d[1]} * d[1]);
         s30[0] = -unit_q30(d[1], len, ng[1]);
         s30[1] = unit_q30(d[0], len, ng[0]);
      end
      s30[2] = 0;

      dip[0] = -(n30[2] * s30[1]);
      dip[1] = n30[2] * s30[0];
      dip[2] = n30[0] * s30[1] - n30[1] * s30[0];

      f.ne = to_unit(n30[0], 16);
      f.nn = to_unit(n30[1], 16);
      f.nu = to_unit(n30[2], 16);
      f.se = to_unit(s30[0], 16);
      f.sn = to_unit(s30[1], 16);
      f.su = to_unit(s30[2], 16);
      f.de = to_unit(dip[0], 46);
      f.dn = to_unit(dip[1], 46);
      f.du = to_unit(dip[2], 46);
      return f;
   endfunction

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   initial begin
      errors     = 0;
      pending    = 0;
      flat_count = 0;
   end

   always @(posedge clock) begin
      frame_t want;
      if (!reset) begin
         if (strobe) begin
            if (frame_q.size() == 0) begin
               report("result with no item outstanding");
            end else begin
               want = frame_q.pop_front();
               check_field("normal_east", 64'(rsp_normal_east), 64'(want.ne));
               check_field("normal_north", 64'(rsp_normal_north), 64'(want.nn));
               check_field("normal_up", 64'(rsp_normal_up), 64'(want.nu));
               check_field("strike_east", 64'(rsp_strike_east), 64'(want.se));
               check_field("strike_north", 64'(rsp_strike_north), 64'(want.sn));
               check_field("strike_up", 64'(rsp_strike_up), 64'(want.su));
               check_field("dip_east", 64'(rsp_dip_east), 64'(want.de));
               check_field("dip_north", 64'(rsp_dip_north), 64'(want.dn));
               check_field("dip_up", 64'(rsp_dip_up), 64'(want.du));
               check_field("patch_area", 64'(rsp_patch_area), 64'(want.area));
               check_field("degenerate", 64'(rsp_degenerate), 64'(want.degen));
            end
         end
         if (start && !busy) begin
            want = predict_frame({req_p3_up, req_p3_north, req_p3_east,
                                  req_p2_up, req_p2_north, req_p2_east,
                                  req_p1_up, req_p1_north, req_p1_east});
            if (want.degen) flat_count++;
            frame_q.push_back(want);
         end
      end
      pending <= frame_q.size();
   end

endmodule

[verif/tb_triangle_patch_frame.sv]
`timescale 1ns / 100ps

module tb_triangle_patch_frame;

   localparam int CB = 24;
   localparam logic [CB-1:0] C_MAX = 24'h7fffff;
   localparam logic [CB-1:0] C_MIN = 24'h800000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [CB-1:0] req_p1_east = 0, req_p1_north = 0, req_p1_up = 0;
   logic [CB-1:0] req_p2_east = 0, req_p2_north = 0, req_p2_up = 0;
   logic [CB-1:0] req_p3_east = 0, req_p3_north = 0, req_p3_up = 0;
   logic strobe;
   logic [tpf_pkg::UNIT_W-1:0] rsp_normal_east, rsp_normal_north, rsp_normal_up;
   logic [tpf_pkg::UNIT_W-1:0] rsp_strike_east, rsp_strike_north, rsp_strike_up;
   logic [tpf_pkg::UNIT_W-1:0] rsp_dip_east, rsp_dip_north, rsp_dip_up;
   logic [tpf_pkg::AREA_W-1:0] rsp_patch_area;
   logic rsp_degenerate;
   int errors, pending, flat_count;
   int sent;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   triangle_patch_frame DUT (.*);

   triangle_patch_frame_checker u_checker (.*);

   function automatic logic [8:0][CB-1:0] tri9(input logic [CB-1:0] e1, n1, u1,
                                               e2, n2, u2, e3, n3, u3);
      return {u3, n3, e3, u2, n2, e2, u1, n1, e1};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [CB-1:0] small_coord();
      return CB'($urandom_range(0, 400)) - CB'(200);
   endfunction

   function automatic logic [CB-1:0] edge_coord();
      case ($urandom_range(0, 4))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3: return '1;
         default: return CB'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [8:0][CB-1:0] v, input int gap);
      start        <= 1'b1;
      req_p1_east  <= v[0];
      req_p1_north <= v[1];
      req_p1_up    <= v[2];
      req_p2_east  <= v[3];
      req_p2_north <= v[4];
      req_p2_up    <= v[5];
      req_p3_east  <= v[6];
      req_p3_north <= v[7];
      req_p3_up    <= v[8];
      do @(posedge clock); while (busy);
      sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [8:0][CB-1:0] random_tri();
      logic [8:0][CB-1:0] v;
      logic [CB-1:0] de, dn, du, ux;
      int mode, t;
      mode = $urandom_range(0, 99);
      for (int i = 0; i < 9; i++) v[i] = CB'($urandom);
      if (mode < 50) begin
      end else if (mode < 68) begin
         for (int i = 0; i < 9; i++) v[i] = small_coord();
      end else if (mode < 78) begin
         // collinear points
         for (int i = 0; i < 3; i++) v[i] = small_coord();
         de = small_coord();
         dn = small_coord();
         du = small_coord();
         t  = $urandom_range(0, 6) - 3;
         v[3] = v[0] + de;
         v[4] = v[1] + dn;
         v[5] = v[2] + du;
         v[6] = v[0] + CB'(t) * de;
         v[7] = v[1] + CB'(t) * dn;
         v[8] = v[2] + CB'(t) * du;
      end else if (mode < 88) begin
         // level patch
         ux   = ($urandom_range(0, 3) == 0) ? small_coord() : CB'($urandom);
         v[2] = ux;
         v[5] = ux;
         v[8] = ux;
      end else if (mode < 94) begin
         for (int i = 0; i < 9; i++) v[i] = edge_coord();
      end else begin
         // vertical patch, plan view collinear
         ux   = CB'($urandom);
         v[0] = ux;
         v[3] = ux;
         v[6] = ux;
      end
      return v;
   endfunction

   initial begin
      #2000000;
      $display("triangle_patch_frame regression: fail");
      $finish;
   end

   initial begin
      int gap;
      int burst;
      sent  = 0;
      burst = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      send_item(tri9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(tri9(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX), 1);
      send_item(tri9(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX), 0);
      send_item(tri9(C_MIN, C_MIN, 0, C_MAX, C_MIN, 0, C_MIN, C_MAX, 0), 2);
      send_item(tri9(0, 0, 5, 10, 0, 5, 0, 10, 5), 0);
      send_item(tri9(0, 0, -5, 10, 0, -5, 0, 10, -5), 0);
      send_item(tri9(0, 0, 0, 10, 0, 0, 0, 10, 0), 3);
      send_item(tri9(0, 0, 7, 0, 10, 7, 10, 0, 7), 0);
      send_item(tri9(0, 0, 0, 1, 0, 0, 0, 0, 1), 0);
      send_item(tri9(0, 0, 0, 0, 1, 0, 1, 0, 0), 1);
      send_item(tri9(1, 2, 3, 2, 4, 6, 3, 6, 9), 0);
      send_item(tri9(5, 5, 5, 5, 5, 5, 5, 5, 5), 0);
      send_item(tri9(0, 0, 0, 1, 0, 0, 0, 1, 1000), 0);
      send_item(tri9(C_MAX, 0, 0, C_MIN, 0, 0, 0, C_MAX, C_MAX), 4);
      send_item(tri9(3, -4, 2, -7, 9, 1, 6, 2, -8), 0);
      send_item(tri9(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0);

      for (int n = 0; n < 1540; n++) begin
         if (burst > 0) begin
            gap = 0;
            burst--;
         end else begin
            gap = pick_gap();
            if ($urandom_range(0, 199) == 0) burst = $urandom_range(30, 80);
         end
         if (n == 700) begin
            send_item(random_tri(), 1);
            while (pending != 0) @(posedge clock);
         end else begin
            send_item(random_tri(), gap);
         end
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("sent %0d triangles: directed corners, level, vertical, collinear and random",
               sent);
      $display("%0d of them had zero area", flat_count);
      if (errors == 0 && pending == 0) begin
         $display("triangle_patch_frame regression: pass");
      end else begin
         $display("triangle_patch_frame regression: fail");
      end
      $finish;
   end

endmodule
